// ----- rtl/core/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
// Item and result structs, register indexes and register reset values.
// No dependencies.
`default_nettype none

package uer_pkg;

	// fields of one input transfer
	typedef struct packed {
		logic cmd;
		logic channel;
		logic echo_a;
		logic echo_b;
	} item_t;

	// fields of one result transfer
	typedef struct packed {
		logic        trigger_a;
		logic        trigger_b;
		logic        busy_res;
		logic        done_res;
		logic [15:0] distance;
		logic        no_echo;
	} result_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_JUMP     = 3'd5;

	localparam logic [13:0] RST_TIMEOUT  = 14'd10000;
	localparam logic [7:0]  RST_TRIGGER  = 8'd11;
	localparam logic [11:0] RST_CPU      = 12'd230;
	localparam logic [7:0]  RST_FAR      = 8'd100;
	localparam logic [7:0]  RST_NEAR     = 8'd7;
	localparam logic [7:0]  RST_JUMP     = 8'd50;
	localparam logic [15:0] RST_LAST     = 16'd25600;

	// item commands
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/ultrasonic_echo_ranger.sv -----
// Tick-driven trigger/echo ranger for two ultrasonic sensors.
// Holds the phase sequencer, the shared restoring divider and the spike filter.
// Depends on uer_pkg.
`default_nettype none

// One result per input transfer; start items and non-dividing ticks load it
// into the output register on acceptance. A tick that ends the echo-high phase
// with a count below the limit runs the count*256 / counts_per_unit divide on
// one shared subtract-and-compare unit, one quotient bit per cycle. The input
// is stalled meanwhile, and also while a result sits unaccepted in the output
// register. Distance is unsigned Q8.8, saturated at 65535. The user must write
// configuration only between measurements; the block does not enforce it.
module ultrasonic_echo_ranger
	import uer_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 14
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output      logic                  item_stall,
	input  wire item_t                 item,
	output      logic                  res_valid,
	input  wire logic                  res_stall,
	output      result_t               res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned CMPW = (COUNT_WIDTH > 14) ? COUNT_WIDTH : 14;
	localparam int unsigned QW   = COUNT_WIDTH + 8;
	localparam int unsigned DCW  = $clog2(QW + 1);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_TRIG = 4'b0010,
		PH_RISE = 4'b0100,
		PH_HIGH = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		SQ_READY = 3'b001,
		SQ_DIV   = 3'b010,
		SQ_FIN   = 3'b100
	} seq_t;

	// configuration
	logic [13:0] timeout_q;
	logic [7:0]  trigger_q;
	logic [11:0] cpu_q;
	logic [7:0]  far_q;
	logic [7:0]  near_q;
	logic [7:0]  jump_q;

	phase_t                 phase_q, phase_d;
	seq_t                   seq_q;
	logic                   chan_q, chan_d;
	logic [COUNT_WIDTH-1:0] tick_q, tick_d;
	logic [15:0]            last_q;

	logic [11:0]            rem_q;
	logic [QW-1:0]          quo_q;
	logic [DCW-1:0]         div_cnt_q;

	logic                   out_valid_q;
	result_t                out_q;

	logic                   accept;
	logic                   echo;
	logic [COUNT_WIDTH-1:0] t_bump;
	logic                   done_d, noecho_d, do_filter, start_div;
	logic                   imm_load, fin_load;
	logic [12:0]            trial;
	logic                   trial_ge;
	logic [QW+7:0]          quo_wide;
	logic [15:0]            quo_sat, far_d, filt_in, filt_out;
	logic [15:0]            near_d, jump_d;

	function automatic logic hit(input logic [COUNT_WIDTH-1:0] t, input logic [13:0] lim);
		hit = (CMPW'(t) >= CMPW'(lim)) || (t == CNT_MAX);
	endfunction

	assign accept     = item_valid && !item_stall;
	assign item_stall = (seq_q != SQ_READY) || (out_valid_q && res_stall);
	assign echo       = chan_q ? item.echo_b : item.echo_a;
	assign t_bump     = (tick_q == CNT_MAX) ? tick_q : tick_q + 1'b1;
	assign far_d      = {far_q, 8'd0};
	assign near_d     = {near_q, 8'd0};
	assign jump_d     = {jump_q, 8'd0};

	// phase sequencer for one item
	always_comb begin
		phase_d   = phase_q;
		chan_d    = chan_q;
		tick_d    = tick_q;
		done_d    = 1'b0;
		noecho_d  = 1'b0;
		do_filter = 1'b0;
		start_div = 1'b0;
		if (item.cmd == CMD_START) begin
			if (phase_q == PH_IDLE) begin
				phase_d = PH_TRIG;
				chan_d  = item.channel;
				tick_d  = '0;
			end
		end else begin
			case (phase_q)
				PH_TRIG: begin
					tick_d = t_bump;
					if (CMPW'(t_bump) >= CMPW'(trigger_q) || t_bump == CNT_MAX) begin
						phase_d = PH_RISE;
						tick_d  = '0;
					end
				end
				PH_RISE: begin
					if (echo && !hit(tick_q, timeout_q)) begin
						phase_d = PH_HIGH;
						tick_d  = '0;
					end else begin
						tick_d = echo ? tick_q : t_bump;
						if (hit(tick_d, timeout_q)) begin
							phase_d  = PH_IDLE;
							done_d   = 1'b1;
							noecho_d = 1'b1;
						end
					end
				end
				PH_HIGH: begin
					if (echo) begin
						tick_d = t_bump;
						if (hit(t_bump, timeout_q)) begin
							phase_d   = PH_IDLE;
							done_d    = 1'b1;
							do_filter = 1'b1;
						end
					end else begin
						phase_d = PH_IDLE;
						done_d  = 1'b1;
						if (hit(tick_q, timeout_q))
							do_filter = 1'b1;
						else
							start_div = 1'b1;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// shared divider step
	assign trial    = {rem_q, quo_q[QW-1]};
	assign trial_ge = trial >= {1'b0, cpu_q};
	assign quo_wide = {8'd0, quo_q};
	assign quo_sat  = (|quo_wide[QW+7:16]) ? 16'hFFFF : quo_wide[15:0];

	// spike filter, fed either by the far distance or the quotient
	assign filt_in  = (seq_q == SQ_FIN) ? quo_sat : far_d;
	assign filt_out = (filt_in < near_d && last_q > filt_in && (last_q - filt_in) > jump_d)
		? last_q : filt_in;

	assign imm_load = accept && !start_div;
	assign fin_load = (seq_q == SQ_FIN) && (!out_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= RST_TIMEOUT;
			trigger_q <= RST_TRIGGER;
			cpu_q     <= RST_CPU;
			far_q     <= RST_FAR;
			near_q    <= RST_NEAR;
			jump_q    <= RST_JUMP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_wdata;
				CFG_TRIGGER: trigger_q <= cfg_wdata[7:0];
				CFG_CPU:     cpu_q     <= cfg_wdata[11:0];
				CFG_FAR:     far_q     <= cfg_wdata[7:0];
				CFG_NEAR:    near_q    <= cfg_wdata[7:0];
				CFG_JUMP:    jump_q    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			seq_q       <= SQ_READY;
			chan_q      <= 1'b0;
			tick_q      <= '0;
			last_q      <= RST_LAST;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				chan_q  <= chan_d;
				tick_q  <= tick_d;
				if (do_filter)
					last_q <= filt_out;
			end
			case (seq_q)
				SQ_READY: begin
					if (accept && start_div) begin
						seq_q     <= SQ_DIV;
						div_cnt_q <= DCW'(QW);
					end
				end
				SQ_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DCW'(1))
						seq_q <= SQ_FIN;
				end
				SQ_FIN: begin
					if (fin_load) begin
						last_q <= filt_out;
						seq_q  <= SQ_READY;
					end
				end
				default: seq_q <= SQ_READY;
			endcase
			if (imm_load || fin_load)
				out_valid_q <= 1'b1;
			else if (!res_stall)
				out_valid_q <= 1'b0;
		end
	end

	// divider datapath and output register
	always_ff @(posedge clk) begin
		if (accept && start_div) begin
			rem_q <= '0;
			quo_q <= {tick_q, 8'd0};
		end else if (seq_q == SQ_DIV) begin
			rem_q <= trial_ge ? 12'(trial - {1'b0, cpu_q}) : trial[11:0];
			quo_q <= {quo_q[QW-2:0], trial_ge};
		end
		if (imm_load) begin
			out_q.trigger_a <= (phase_d == PH_TRIG) && !chan_d;
			out_q.trigger_b <= (phase_d == PH_TRIG) && chan_d;
			out_q.busy_res  <= phase_d != PH_IDLE;
			out_q.done_res  <= done_d;
			out_q.distance  <= noecho_d ? far_d : (do_filter ? filt_out : 16'd0);
			out_q.no_echo   <= noecho_d;
		end else if (fin_load) begin
			out_q.trigger_a <= 1'b0;
			out_q.trigger_b <= 1'b0;
			out_q.busy_res  <= 1'b0;
			out_q.done_res  <= 1'b1;
			out_q.distance  <= filt_out;
			out_q.no_echo   <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	// divide only runs once the measurement has left its phases
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != SQ_READY |-> phase_q == PH_IDLE)
		else $error("divider busy while a measurement phase is active");

	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SQ_DIV |-> div_cnt_q != '0)
		else $error("divide step count ran out inside the divide");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.done_res && res.busy_res))
		else $error("result both done and busy");

	a_one_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.trigger_a && res.trigger_b))
		else $error("both trigger lines high");

endmodule

`default_nettype wire

// ----- verif/tb_ultrasonic_echo_ranger.sv -----
// Self-checking testbench for ultrasonic_echo_ranger: directed corner runs, then random runs.
// A scoreboard class predicts every result from the accepted items and checks them in order.
// Depends on uer_pkg and the ranger RTL.
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger;
	import uer_pkg::*;

	localparam int unsigned COUNT_W = 14;
	localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES = 32;
	localparam int unsigned RANDOM_ITEMS = 240;
	localparam int unsigned MIN_READINGS = 40;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TRIGGER,
		ST_WAIT_RISE,
		ST_ECHO_HIGH
	} ranger_state_t;

	class ranger_scoreboard;
		logic [13:0]        timeout_lim;
		logic [7:0]         trig_len;
		logic [11:0]        cnt_per_unit;
		logic [7:0]         far_units;
		logic [7:0]         near_units;
		logic [7:0]         jump_units;
		ranger_state_t      st;
		logic               chan;
		logic [COUNT_W-1:0] ticks;
		logic [15:0]        last_dist;
		result_t            pending_q[$];
		int unsigned        errors;
		int unsigned        readings;

		function new();
			timeout_lim  = RST_TIMEOUT;
			trig_len     = RST_TRIGGER;
			cnt_per_unit = RST_CPU;
			far_units    = RST_FAR;
			near_units   = RST_NEAR;
			jump_units   = RST_JUMP;
			st           = ST_IDLE;
			chan         = 1'b0;
			ticks        = '0;
			last_dist    = RST_LAST;
			errors       = 0;
			readings     = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
			CFG_TIMEOUT: timeout_lim  = val[13:0];
			CFG_TRIGGER: trig_len     = val[7:0];
			CFG_CPU:     cnt_per_unit = val[11:0];
			CFG_FAR:     far_units    = val[7:0];
			CFG_NEAR:    near_units   = val[7:0];
			CFG_JUMP:    jump_units   = val[7:0];
			default: ;
			endcase
		endfunction

		function bit at_limit();
			return (ticks >= timeout_lim) || (ticks == COUNT_TOP);
		endfunction

		function void advance();
			if (ticks != COUNT_TOP)
				ticks++;
		endfunction

		// count*256 / counts_per_unit, truncated, saturated; zero divisor saturates
		function logic [15:0] quantize(logic [COUNT_W-1:0] n);
			logic [COUNT_W+7:0] dividend;
			logic [COUNT_W+7:0] q;
			dividend = {n, 8'h00};
			if (cnt_per_unit == 12'd0)
				return 16'hFFFF;
			q = dividend / cnt_per_unit;
			return (q > 16'hFFFF) ? 16'hFFFF : q[15:0];
		endfunction

		// a near reading far below the previous one is a spike: keep the previous one
		function logic [15:0] despike(logic [15:0] d);
			if (d < {near_units, 8'h00} && last_dist > d && (last_dist - d) > {jump_units, 8'h00})
				d = last_dist;
			last_dist = d;
			return d;
		endfunction

		function void note_item(item_t it);
			logic    echo;
			result_t exp;
			echo = chan ? it.echo_b : it.echo_a;
			exp = '0;
			if (it.cmd == CMD_START) begin
				if (st == ST_IDLE) begin
					st = ST_TRIGGER;
					chan = it.channel;
					ticks = '0;
				end
			end else begin
				case (st)
				ST_TRIGGER: begin
					advance();
					if (ticks >= trig_len || ticks == COUNT_TOP) begin
						st = ST_WAIT_RISE;
						ticks = '0;
					end
				end
				ST_WAIT_RISE: begin
					if (echo && !at_limit()) begin
						st = ST_ECHO_HIGH;
						ticks = '0;
					end else begin
						if (!echo)
							advance();
						if (at_limit()) begin
							st = ST_IDLE;
							exp.done_res = 1'b1;
							exp.no_echo = 1'b1;
							exp.distance = {far_units, 8'h00};
						end
					end
				end
				ST_ECHO_HIGH: begin
					if (echo) begin
						advance();
						if (at_limit()) begin
							st = ST_IDLE;
							exp.done_res = 1'b1;
							exp.distance = despike({far_units, 8'h00});
						end
					end else begin
						st = ST_IDLE;
						exp.done_res = 1'b1;
						exp.distance = despike(at_limit() ? {far_units, 8'h00} : quantize(ticks));
					end
				end
				default: st = ST_IDLE;
				endcase
			end
			exp.trigger_a = (st == ST_TRIGGER) && !chan;
			exp.trigger_b = (st == ST_TRIGGER) && chan;
			exp.busy_res  = (st != ST_IDLE);
			if (exp.done_res)
				readings++;
			pending_q.push_back(exp);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
			if (want !== seen) begin
				$error("%s: expected %0d, got %0d", name, want, seen);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending_q.size() == 0) begin
				$error("result transfer with nothing pending");
				errors++;
				return;
			end
			exp = pending_q.pop_front();
			compare_field("trigger_a", 16'(exp.trigger_a), 16'(got.trigger_a));
			compare_field("trigger_b", 16'(exp.trigger_b), 16'(got.trigger_b));
			compare_field("busy_res", 16'(exp.busy_res), 16'(got.busy_res));
			compare_field("done_res", 16'(exp.done_res), 16'(got.done_res));
			compare_field("distance", exp.distance, got.distance);
			compare_field("no_echo", 16'(exp.no_echo), 16'(got.no_echo));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	result_t               res;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	logic                  no_gaps = 1'b0;
	int unsigned           idle_cycles = 0;
	int unsigned           sent_items = 0;
	ranger_scoreboard      sb;

	ultrasonic_echo_ranger dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		res_stall <= !no_gaps && ($urandom_range(0, 99) < 35);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res);
	end

	// ends the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(input item_t it);
		while (!no_gaps && $urandom_range(0, 99) < 35) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(it);
		sent_items++;
		@(negedge clk);
	endtask

	function automatic item_t random_item();
		item_t it;
		it.cmd     = 1'($urandom_range(0, 1));
		it.channel = 1'($urandom_range(0, 1));
		it.echo_a  = 1'($urandom_range(0, 1));
		it.echo_b  = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// tick with the active echo at level; the other echo is noise
	function automatic item_t echo_tick(logic level);
		item_t it;
		it = random_item();
		it.cmd = CMD_TICK;
		if (sb.chan)
			it.echo_b = level;
		else
			it.echo_a = level;
		return it;
	endfunction

	task automatic step(input logic level, input bit noisy);
		item_t it;
		if (noisy && $urandom_range(0, 99) < 4) begin
			it = random_item();
			it.cmd = CMD_START;
		end else begin
			it = echo_tick(level);
		end
		send_item(it);
	endtask

	task automatic measure(input logic ch, input int unsigned rise_wait,
			input int unsigned high_len, input bit noisy);
		item_t       it;
		int unsigned n;
		it = random_item();
		it.cmd = CMD_START;
		it.channel = ch;
		send_item(it);
		while (sb.st == ST_TRIGGER)
			step(1'($urandom_range(0, 1)), noisy);
		n = 0;
		while (sb.st == ST_WAIT_RISE && n < rise_wait) begin
			step(1'b0, noisy);
			n++;
		end
		n = 0;
		while (sb.st != ST_IDLE && n < high_len) begin
			step(1'b1, noisy);
			n++;
		end
		while (sb.st != ST_IDLE)
			step(1'b0, 1'b0);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic configure(input int unsigned tmo, input int unsigned trg, input int unsigned cpu,
			input int unsigned far, input int unsigned near, input int unsigned jump);
		settle();
		write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
		write_reg(CFG_TRIGGER, CFG_DATA_W'(trg));
		write_reg(CFG_CPU, CFG_DATA_W'(cpu));
		write_reg(CFG_FAR, CFG_DATA_W'(far));
		write_reg(CFG_NEAR, CFG_DATA_W'(near));
		write_reg(CFG_JUMP, CFG_DATA_W'(jump));
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned base_items;
		int unsigned base_readings;
		int unsigned phase_no;
		int unsigned phase_start;
		int unsigned tmo;
		int unsigned kind;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: a short echo is a spike against the reset distance
		measure(1'b0, 2, 5, 1'b0);

		// zero-length trigger, zero divisor, echo-rise timeout, echo-high timeout
		configure(6, 0, 0, 255, 0, 0);
		measure(1'b1, 1, 2, 1'b0);
		measure(1'b0, 10, 0, 1'b0);
		measure(1'b1, 0, 10, 1'b1);

		// zero timeout: echo already high at the limit
		configure(0, 3, 4095, 0, 255, 255);
		measure(1'b0, 0, 1, 1'b0);

		// widest timeout: quotient saturation with a divisor of one
		configure(16383, 1, 1, 200, 255, 0);
		measure(1'b0, 0, 260, 1'b0);

		base_items = sent_items;
		base_readings = sb.readings;
		phase_no = 0;
		while (sent_items - base_items < RANDOM_ITEMS || sb.readings - base_readings < MIN_READINGS)
				begin
			tmo = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(4, 80);
			configure(tmo,
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4),
				($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 24),
				$urandom_range(0, 255),
				$urandom_range(0, 255),
				$urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 20));
			no_gaps <= (phase_no == 2);
			phase_start = sent_items;
			while (sent_items - phase_start < 80) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					measure(1'($urandom_range(0, 1)), tmo + 2, 0, 1'b1);
				end else if (kind == 1) begin
					// raw items, then finish whatever they started
					repeat ($urandom_range(1, 6)) send_item(random_item());
					while (sb.st != ST_IDLE)
						send_item(echo_tick(1'b0));
				end else begin
					measure(1'($urandom_range(0, 1)), $urandom_range(0, tmo / 2),
						$urandom_range(1, tmo + 2), 1'b1);
				end
			end
			phase_no++;
		end

		settle();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
